[rtl/core/shdl_pkg.sv]
// ----------------------------------------------------------------------------
// shdl_pkg
// Shared types, codes and constants of the sorted hash directory lookup.
// ----------------------------------------------------------------------------
package shdl_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 1024;

	localparam logic [31:0] SALT_MARK  = 32'hffff_ffff;
	localparam logic [31:0] PATCH_MARK = 32'hffff_fffe;
	localparam logic [31:0] POS_BIAS   = 32'd24;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_HASH  = 2'd1,
		KIND_INDEX = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_LOADED    = 4'd0,
		ST_FILE      = 4'd1,
		ST_PATCH     = 4'd2,
		ST_SALTED    = 4'd3,
		ST_NOT_FOUND = 4'd4,
		ST_BAD_INDEX = 4'd5,
		ST_NOT_ASC   = 4'd6,
		ST_NOT_READY = 4'd7,
		ST_REFUSED   = 4'd8
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] file_position;
		logic [31:0] found_size;
		logic [31:0] salt_value;
		logic [9:0]  hit_position;
	} res_t;

	function automatic res_t make_res(status_t st, logic [9:0] hit);
		res_t r;
		r = '0;
		r.status = st;
		r.hit_position = hit;
		return r;
	endfunction

	// a stored entry seen as a patch or as a file
	function automatic res_t report_entry(logic [31:0] off, logic [31:0] size,
		logic [9:0] hit);
		res_t r;
		r = '0;
		r.hit_position = hit;
		r.found_size = size;
		if (off == PATCH_MARK) begin
			r.status = ST_PATCH;
		end else begin
			r.status = ST_FILE;
			r.file_position = off + POS_BIAS;
		end
		return r;
	endfunction

endpackage

[rtl/core/sorted_hash_directory_lookup.sv]
// ----------------------------------------------------------------------------
// sorted_hash_directory_lookup
// Loads a table of entries with strictly ascending 64-bit hashes into one
// memory and answers lookups by binary search over the hashes or by index.
//
// channel   dir  handshake        payload
// s_*       in   tvalid/tready    tuser kind, tdata entry and query fields
// m_*       out  tvalid/tready    tuser status, tdata result fields
// apb       in   psel/penable     entry_count register at byte address 0
//
// load, refused, not ready and bad index: result registered straight from the accepted word
// lookup by index: one memory read, then the result is registered in S_IDX
// lookup by hash: each probe reads in S_SEARCH and compares in S_CMP, a loop
// on the single memory read port until a hit or an empty search range
// reset clears the state, the counts and flags only; the table memory is not cleared
// a new word is taken only when idle and the result register is free or drains
// ----------------------------------------------------------------------------
module sorted_hash_directory_lookup
	import shdl_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_hash, entry_offset, entry_size, entry_third, query_hash,
	// query_index, salted_retry, zero fill
	input  logic [239:0] s_tdata,
	// kind
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// file_position, found_size, salt_value, hit_position, zero fill
	output logic [111:0] m_tdata,
	// status
	output logic [3:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_CMP    = 4'b0100,
		S_IDX    = 4'b1000
	} state_t;

	state_t         state_q, state_d;
	logic           out_valid_q, out_valid_d;
	res_t           res_q, res_d;
	logic           res_set;
	logic [CW-1:0]  ec_q, ec_d;
	logic [CW-1:0]  loaded_q, loaded_d;
	logic           ready_q, ready_d;
	logic           failed_q, failed_d;
	logic [63:0]    last_key_q, last_key_d;
	logic [63:0]    query_q, query_d;
	logic           retry_q, retry_d;
	logic [CW-1:0]  lo_q, lo_d;
	logic [CW-1:0]  hi_q, hi_d;
	logic [CW-1:0]  mid_q, mid_d;

	logic [127:0]   mem [MAX_ENTRIES];
	logic [127:0]   rdata_q;
	logic           mem_we;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	logic [127:0]   wdata;

	logic           acc;
	logic           cfg_we;
	logic [31:0]    cfg_wv;
	logic [31:0]    cfg_ec;
	kind_t          kind;
	logic [63:0]    in_hash;
	logic [31:0]    in_off;
	logic [31:0]    in_size;
	logic [31:0]    in_third;
	logic [63:0]    in_qhash;
	logic [9:0]     in_qidx;
	logic           in_retry;
	logic [31:0]    p32;
	logic [31:0]    idx32;
	logic [31:0]    mid32;
	logic [31:0]    ec32;
	logic [CW:0]    mid_sum;
	logic [CW-1:0]  mid_w;
	logic [63:0]    rd_key;
	logic [31:0]    rd_off;
	logic [31:0]    rd_size;

	assign kind     = kind_t'(s_tuser);
	assign in_hash  = s_tdata[63:0];
	assign in_off   = s_tdata[95:64];
	assign in_size  = s_tdata[127:96];
	assign in_third = s_tdata[159:128];
	assign in_qhash = s_tdata[223:160];
	assign in_qidx  = s_tdata[233:224];
	assign in_retry = s_tdata[234];

	assign rd_key  = rdata_q[127:64];
	assign rd_off  = rdata_q[63:32];
	assign rd_size = rdata_q[31:0];

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	assign pready = 1'b1;
	assign prdata = 32'(ec_q);
	assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
	assign cfg_wv = {21'b0, pwdata[10:0]};
	assign cfg_ec = (cfg_wv > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : cfg_wv;

	assign p32     = 32'(loaded_q);
	assign idx32   = 32'(in_qidx);
	assign mid32   = 32'(mid_q);
	assign ec32    = 32'(ec_q);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[CW:1];

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {6'b0, res_q.hit_position, res_q.salt_value, res_q.found_size,
		res_q.file_position};

	always_comb begin
		state_d    = state_q;
		loaded_d   = loaded_q;
		ready_d    = ready_q;
		failed_d   = failed_q;
		ec_d       = ec_q;
		last_key_d = last_key_q;
		query_d    = query_q;
		retry_d    = retry_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		res_set    = 1'b0;
		res_d      = res_q;
		mem_we     = 1'b0;
		waddr      = p32[AW-1:0];
		wdata      = {in_hash, in_off, in_size};
		raddr      = mid_w[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (kind)
						KIND_LOAD: begin
							res_set = 1'b1;
							if (ready_q || failed_q || loaded_q >= ec_q) begin
								res_d = make_res(ST_REFUSED, 10'd0);
							end else if (loaded_q != '0 && last_key_q >= in_hash) begin
								failed_d = 1'b1;
								res_d = make_res(ST_NOT_ASC, p32[9:0]);
							end else begin
								mem_we = 1'b1;
								if (in_off == SALT_MARK && in_size == 32'd0) begin
									wdata = {in_hash, PATCH_MARK, in_third};
								end
								last_key_d = in_hash;
								loaded_d = loaded_q + CW'(1);
								if (loaded_q + CW'(1) == ec_q) begin
									ready_d = 1'b1;
								end
								res_d = make_res(ST_LOADED, p32[9:0]);
							end
						end
						KIND_HASH: begin
							if (!ready_q) begin
								res_set = 1'b1;
								res_d = make_res(ST_NOT_READY, 10'd0);
							end else begin
								lo_d = '0;
								hi_d = ec_q;
								query_d = in_qhash;
								retry_d = in_retry;
								state_d = S_SEARCH;
							end
						end
						KIND_INDEX: begin
							if (!ready_q) begin
								res_set = 1'b1;
								res_d = make_res(ST_NOT_READY, 10'd0);
							end else if (idx32 >= ec32) begin
								res_set = 1'b1;
								res_d = make_res(ST_BAD_INDEX, 10'd0);
							end else begin
								raddr = idx32[AW-1:0];
								mid_d = idx32[CW-1:0];
								state_d = S_IDX;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					mid_d = mid_w;
					state_d = S_CMP;
				end else begin
					res_set = 1'b1;
					res_d = make_res(ST_NOT_FOUND, 10'd0);
					state_d = S_IDLE;
				end
			end
			S_CMP: begin
				if (query_q == rd_key) begin
					res_set = 1'b1;
					state_d = S_IDLE;
					if (rd_off == SALT_MARK) begin
						if (retry_q) begin
							res_d = make_res(ST_NOT_FOUND, 10'd0);
						end else begin
							res_d = make_res(ST_SALTED, mid32[9:0]);
							res_d.salt_value = rd_size;
						end
					end else begin
						res_d = report_entry(rd_off, rd_size, mid32[9:0]);
					end
				end else if (query_q > rd_key) begin
					lo_d = mid_q + CW'(1);
					state_d = S_SEARCH;
				end else begin
					hi_d = mid_q;
					state_d = S_SEARCH;
				end
			end
			S_IDX: begin
				res_set = 1'b1;
				res_d = report_entry(rd_off, rd_size, mid32[9:0]);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_we) begin
			ec_d = cfg_ec[CW-1:0];
			loaded_d = '0;
			failed_d = 1'b0;
			ready_d = (cfg_ec == 32'd0);
		end

		out_valid_d = out_valid_q && !m_tready;
		if (res_set) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ec_q        <= '0;
			loaded_q    <= '0;
			ready_q     <= 1'b0;
			failed_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			ec_q        <= ec_d;
			loaded_q    <= loaded_d;
			ready_q     <= ready_d;
			failed_q    <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			res_q <= res_d;
		end
		last_key_q <= last_key_d;
		query_q    <= query_d;
		retry_q    <= retry_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		mid_q      <= mid_d;
	end

	// table memory, one entry is {key, offset, size}
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	a_cmp_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_SEARCH)
		else $error("compare step without a preceding read");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> loaded_q == ec_q && !failed_q)
		else $error("table ready with entries missing or load failed");

	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q)
		else $error("lookup running while a result is pending");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> hi_q <= ec_q && lo_q <= hi_q)
		else $error("search bounds out of table range");

endmodule

[test/sorted_hash_directory_lookup_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_hash_directory_lookup_tb
// Loads directory tables of random sizes through the entry_count register
// and the input stream, then runs hash and index lookups against them. Every
// result word is checked field by field against a behavioral copy of the
// table kept here or a fixed answer. A short directed table comes first, then
// random tables with broken loads, noise words and handshake stalls on both sides.
// ----------------------------------------------------------------------------
module sorted_hash_directory_lookup_tb;
	import shdl_pkg::*;

	localparam logic [1:0] KIND_UNUSED     = 2'd3;
	localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
	localparam int         SETTLE_CYCLES   = 30;
	localparam int         CYCLE_LIMIT     = 1000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] entry_hash;
		logic [31:0] entry_offset;
		logic [31:0] entry_size;
		logic [31:0] entry_third;
		logic [63:0] query_hash;
		logic [9:0]  query_index;
		logic        salted_retry;
	} dir_word_t;

	typedef struct {
		bit        is_cfg;
		logic [10:0] cfg_value;
		dir_word_t w;
		bit        pinned;
		res_t      pinned_res;
	} step_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [239:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [3:0]   m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// table copy
	logic [63:0] dir_keys    [0:MAX_ENTRIES_DEF-1];
	logic [31:0] dir_offsets [0:MAX_ENTRIES_DEF-1];
	logic [31:0] dir_sizes   [0:MAX_ENTRIES_DEF-1];
	int          dir_count = 0;
	int          dir_loaded = 0;
	bit          dir_ready = 1'b0;
	bit          dir_failed = 1'b0;

	res_t  expected_answers[$];
	step_t plan[$];
	int    mismatches = 0;
	int    words_sent = 0;
	int    cycle_count = 0;
	int    src_idle_pct = 0;
	int    snk_idle_pct = 0;

	sorted_hash_directory_lookup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic dir_word_t random_word(logic [1:0] kind);
		dir_word_t w;
		w.kind = kind;
		w.entry_hash = rand64();
		w.entry_offset = $urandom;
		w.entry_size = $urandom;
		w.entry_third = $urandom;
		w.query_hash = rand64();
		w.query_index = 10'($urandom);
		w.salted_retry = 1'($urandom);
		return w;
	endfunction

	function automatic res_t stored_answer(int i);
		res_t r;
		r = '0;
		r.hit_position = i[9:0];
		r.found_size = dir_sizes[i];
		if (dir_offsets[i] == PATCH_MARK) begin
			r.status = ST_PATCH;
		end else begin
			r.status = ST_FILE;
			r.file_position = dir_offsets[i] + POS_BIAS;
		end
		return r;
	endfunction

	function automatic bit predict_answer(input dir_word_t w, output res_t r);
		int p;
		int lo;
		int hi;
		int mid;
		logic [31:0] off;
		logic [31:0] size;
		r = '0;
		if (w.kind == KIND_LOAD) begin
			p = dir_loaded;
			if (dir_ready || dir_failed || p >= dir_count) begin
				r.status = ST_REFUSED;
			end else if (p > 0 && dir_keys[p-1] >= w.entry_hash) begin
				dir_failed = 1'b1;
				r.status = ST_NOT_ASC;
				r.hit_position = p[9:0];
			end else begin
				off = w.entry_offset;
				size = w.entry_size;
				if (off == SALT_MARK && size == 32'd0) begin
					off = PATCH_MARK;
					size = w.entry_third;
				end
				dir_keys[p] = w.entry_hash;
				dir_offsets[p] = off;
				dir_sizes[p] = size;
				dir_loaded = p + 1;
				if (dir_loaded == dir_count)
					dir_ready = 1'b1;
				r.status = ST_LOADED;
				r.hit_position = p[9:0];
			end
			return 1'b1;
		end
		if (w.kind == KIND_UNUSED)
			return 1'b0;
		if (!dir_ready) begin
			r.status = ST_NOT_READY;
			return 1'b1;
		end
		if (w.kind == KIND_INDEX) begin
			if (int'(w.query_index) >= dir_count)
				r.status = ST_BAD_INDEX;
			else
				r = stored_answer(int'(w.query_index));
			return 1'b1;
		end
		lo = 0;
		hi = dir_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (w.query_hash == dir_keys[mid]) begin
				if (dir_offsets[mid] != SALT_MARK) begin
					r = stored_answer(mid);
				end else if (w.salted_retry) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status = ST_SALTED;
					r.salt_value = dir_sizes[mid];
					r.hit_position = mid[9:0];
				end
				return 1'b1;
			end
			if (w.query_hash > dir_keys[mid])
				lo = mid + 1;
			else
				hi = mid;
		end
		r.status = ST_NOT_FOUND;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected word, status", 64'(m_tuser), 64'd0);
			end else begin
				want = expected_answers.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[31:0] !== want.file_position)
					report_mismatch("file_position", 64'(m_tdata[31:0]),
						64'(want.file_position));
				if (m_tdata[63:32] !== want.found_size)
					report_mismatch("found_size", 64'(m_tdata[63:32]),
						64'(want.found_size));
				if (m_tdata[95:64] !== want.salt_value)
					report_mismatch("salt_value", 64'(m_tdata[95:64]),
						64'(want.salt_value));
				if (m_tdata[105:96] !== want.hit_position)
					report_mismatch("hit_position", 64'(m_tdata[105:96]),
						64'(want.hit_position));
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_word(input dir_word_t w, input bit pinned, input res_t pinned_res);
		res_t r;
		bit has;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.kind;
		s_tdata <= {5'd0, w.salted_retry, w.query_index, w.query_hash, w.entry_third,
			w.entry_size, w.entry_offset, w.entry_hash};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		has = predict_answer(w, r);
		if (has) begin
			expected_answers.push_back(pinned ? pinned_res : r);
			words_sent++;
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_entry_count(input logic [10:0] value);
		logic [31:0] d;
		int v;
		d = $urandom;
		d[10:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ENTRY_COUNT;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v = int'(value);
		dir_count = (v > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : v;
		dir_loaded = 0;
		dir_failed = 1'b0;
		dir_ready = (dir_count == 0);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic step_t cfg_row(logic [10:0] value);
		step_t s;
		s.is_cfg = 1'b1;
		s.cfg_value = value;
		s.w = '0;
		s.pinned = 1'b0;
		s.pinned_res = '0;
		return s;
	endfunction

	function automatic step_t word_row(logic [1:0] kind, logic [63:0] key, logic [31:0] off,
		logic [31:0] size, logic [31:0] third, logic [9:0] idx, logic retry,
		bit pinned, status_t st, logic [9:0] hit);
		step_t s;
		s.is_cfg = 1'b0;
		s.cfg_value = '0;
		s.w = '{kind, key, off, size, third, key, idx, retry};
		s.pinned = pinned;
		s.pinned_res = '0;
		s.pinned_res.status = st;
		s.pinned_res.hit_position = hit;
		return s;
	endfunction

	task automatic run_table(input int reg_value, input int lookups);
		int n;
		int bad_at;
		int i;
		int j;
		int c;
		logic [63:0] key;
		dir_word_t w;
		bit broken;
		settle();
		write_entry_count(reg_value[10:0]);
		n = dir_count;
		broken = (n >= 2) && ($urandom_range(0, 99) < 15);
		bad_at = broken ? $urandom_range(1, n - 1) : n;
		key = rand64() >> 2;
		for (i = 0; i < n; i++) begin
			c = $urandom_range(0, 99);
			if (c < 4)
				send_word(random_word(KIND_UNUSED), 1'b0, '0);
			else if (c < 8)
				send_word(random_word(c < 6 ? KIND_HASH : KIND_INDEX), 1'b0, '0);
			if (i > 0)
				key = key + 64'd1 + (rand64() >> (n > 16 ? 11 : 5));
			w = random_word(KIND_LOAD);
			if (i == bad_at)
				w.entry_hash = $urandom_range(0, 1) ? dir_keys[i-1] : dir_keys[i-1] >> 1;
			else
				w.entry_hash = key;
			c = $urandom_range(0, 99);
			if (c < 12) begin
				w.entry_offset = SALT_MARK;
				w.entry_size = 32'd0;
			end else if (c < 25) begin
				w.entry_offset = SALT_MARK;
			end else if (c < 32) begin
				w.entry_offset = PATCH_MARK;
			end
			send_word(w, 1'b0, '0);
			if (i == bad_at) begin
				repeat ($urandom_range(1, 3))
					send_word(random_word(2'($urandom_range(0, 2))), 1'b0, '0);
				return;
			end
		end
		for (j = 0; j < lookups; j++) begin
			c = $urandom_range(0, 99);
			w = random_word(KIND_HASH);
			if (c < 45 && n > 0) begin
				w.query_hash = dir_keys[$urandom_range(0, n - 1)];
				w.salted_retry = ($urandom_range(0, 99) < 25);
			end else if (c < 60) begin
				if (n > 0 && c < 53)
					w.query_hash = dir_keys[$urandom_range(0, n - 1)] + 64'd1;
			end else if (c < 90) begin
				w.kind = KIND_INDEX;
				if (n > 0)
					w.query_index = 10'($urandom_range(0, n - 1));
			end else if (c < 95) begin
				w.kind = KIND_INDEX;
				if (n < MAX_ENTRIES_DEF)
					w.query_index = 10'($urandom_range(n, MAX_ENTRIES_DEF - 1));
			end else begin
				w.kind = $urandom_range(0, 1) ? KIND_LOAD : KIND_UNUSED;
			end
			send_word(w, 1'b0, '0);
		end
	endtask

	initial begin
		int phase;
		int target;
		int c;
		int i;
		plan.push_back(word_row(KIND_HASH, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_READY, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_READY, 10'd0));
		plan.push_back(word_row(KIND_LOAD, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_REFUSED, 10'd0));
		plan.push_back(word_row(KIND_UNUSED, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b0, ST_LOADED, 10'd0));
		plan.push_back(cfg_row(11'd4));
		plan.push_back(word_row(KIND_LOAD, 64'h0, 32'hffff_ffe8, 32'h0, 32'hffff_ffff,
			10'd0, 1'b0, 1'b1, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_LOAD, 64'h1000_0000_0000_0000, SALT_MARK, 32'h0,
			32'hdead_beef, 10'd0, 1'b0, 1'b1, ST_LOADED, 10'd1));
		plan.push_back(word_row(KIND_LOAD, 64'h2000_0000_0000_0000, SALT_MARK,
			32'h1234_5678, 32'h0, 10'd0, 1'b0, 1'b1, ST_LOADED, 10'd2));
		plan.push_back(word_row(KIND_LOAD, 64'hffff_ffff_ffff_ffff, PATCH_MARK,
			32'hffff_ffff, 32'h0, 10'd0, 1'b0, 1'b1, ST_LOADED, 10'd3));
		plan.push_back(word_row(KIND_LOAD, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_REFUSED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h1000_0000_0000_0000, 32'h0, 32'h0, 32'h0,
			10'd0, 1'b1, 1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h2000_0000_0000_0000, 32'h0, 32'h0, 32'h0,
			10'd0, 1'b0, 1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h2000_0000_0000_0000, 32'h0, 32'h0, 32'h0,
			10'd0, 1'b1, 1'b1, ST_NOT_FOUND, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'hffff_ffff_ffff_ffff, 32'h0, 32'h0, 32'h0,
			10'd0, 1'b0, 1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h1, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_FOUND, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd2, 1'b0,
			1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd3, 1'b0,
			1'b0, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd4, 1'b0,
			1'b1, ST_BAD_INDEX, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd1023, 1'b0,
			1'b1, ST_BAD_INDEX, 10'd0));
		// register value above the maximum
		plan.push_back(cfg_row(11'd2047));
		plan.push_back(word_row(KIND_LOAD, 64'h10, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_LOAD, 64'h10, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_ASC, 10'd1));
		plan.push_back(word_row(KIND_HASH, 64'h10, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_READY, 10'd0));
		plan.push_back(cfg_row(11'd3));
		plan.push_back(word_row(KIND_LOAD, 64'h5, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_LOADED, 10'd0));
		plan.push_back(word_row(KIND_LOAD, 64'h5, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_ASC, 10'd1));
		plan.push_back(word_row(KIND_LOAD, 64'h6, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_REFUSED, 10'd0));
		plan.push_back(word_row(KIND_HASH, 64'h5, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_READY, 10'd0));
		plan.push_back(cfg_row(11'd0));
		plan.push_back(word_row(KIND_HASH, 64'h5, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_NOT_FOUND, 10'd0));
		plan.push_back(word_row(KIND_INDEX, 64'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_BAD_INDEX, 10'd0));
		plan.push_back(word_row(KIND_LOAD, 64'h7, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0,
			1'b1, ST_REFUSED, 10'd0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 73 : 0;
			snk_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 31 : 0;
			if (phase == 0) begin
				for (i = 0; i < plan.size(); i++) begin
					if (plan[i].is_cfg) begin
						settle();
						write_entry_count(plan[i].cfg_value);
					end else begin
						send_word(plan[i].w, plan[i].pinned, plan[i].pinned_res);
					end
				end
			end
			// one deeper table
			if (phase == 2)
				run_table(200, 50);
			target = words_sent + ((phase == 2) ? 100 : 250);
			while (words_sent < target) begin
				c = $urandom_range(0, 99);
				run_table((c < 10) ? 0 : (c < 90) ? $urandom_range(1, 16) :
					$urandom_range(17, 100), $urandom_range(5, 25));
			end
		end
		settle();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
